// ===== rtl/ptps_pkg.sv =====
// Package for the process table priority scheduler.
// Holds command, status and result-state codes and the controller state type.
// No dependencies.
package ptps_pkg;

    localparam logic [2:0] CMD_INSERT  = 3'd0;
    localparam logic [2:0] CMD_FIND    = 3'd1;
    localparam logic [2:0] CMD_DELETE  = 3'd2;
    localparam logic [2:0] CMD_SETPRIO = 3'd3;
    localparam logic [2:0] CMD_DISPATCH = 3'd4;
    localparam logic [2:0] CMD_EXECUTE = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_PRIO  = 3'd1;
    localparam logic [2:0] ST_BAD_MEM   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_EMPTY     = 3'd5;
    localparam logic [2:0] ST_NO_IDS    = 3'd6;

    localparam logic [1:0] PS_NEW        = 2'd0;
    localparam logic [1:0] PS_READY      = 2'd1;
    localparam logic [1:0] PS_TERMINATED = 2'd2;

    localparam logic [3:0]  PRIO_MIN = 4'd1;
    localparam logic [3:0]  PRIO_MAX = 4'd10;
    localparam logic [12:0] MEM_MIN  = 13'd1;
    localparam logic [12:0] MEM_MAX  = 13'd4096;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_APPLY,
        S_RESP
    } t_fsm;

endpackage

// ===== rtl/ptps_cell.sv =====
// One table slot of the scheduler ring.
// Holds an entry and passes it to the next cell on every shift. Depends on nothing.
module ptps_cell #(
    parameter int ID_BITS = 16,
    parameter int TW      = 4,
    parameter int IDX     = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_shift,
    input  logic               i_valid,
    input  logic               i_ready,
    input  logic [ID_BITS-1:0] i_ident,
    input  logic [3:0]         i_prio,
    input  logic [12:0]        i_mem,
    input  logic [TW-1:0]      i_tag,
    input  logic [TW-1:0]      i_spos,
    output logic               o_valid,
    output logic               o_ready,
    output logic [ID_BITS-1:0] o_ident,
    output logic [3:0]         o_prio,
    output logic [12:0]        o_mem,
    output logic [TW-1:0]      o_tag,
    output logic [TW-1:0]      o_spos
);

    logic               r_valid;
    logic               r_ready;
    logic [ID_BITS-1:0] r_ident;
    logic [3:0]         r_prio;
    logic [12:0]        r_mem;
    logic [TW-1:0]      r_tag;
    logic [TW-1:0]      r_spos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ready <= 1'b0;
            r_tag   <= TW'(IDX);
        end else if (i_shift) begin
            r_valid <= i_valid;
            r_ready <= i_ready;
            r_tag   <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_ident <= i_ident;
            r_prio  <= i_prio;
            r_mem   <= i_mem;
            r_spos  <= i_spos;
        end
    end

    assign o_valid = r_valid;
    assign o_ready = r_ready;
    assign o_ident = r_ident;
    assign o_prio  = r_prio;
    assign o_mem   = r_mem;
    assign o_tag   = r_tag;
    assign o_spos  = r_spos;

endmodule

// ===== rtl/process_table_priority_scheduler.sv =====
// Top level of the process table priority scheduler: controller and ring of slot cells.
// Depends on ptps_pkg and ptps_cell.
//
//  channel   | ports             | tdata fields (low bit up)
//  ----------+-------------------+---------------------------------------------
//  command   | i_s_axis_*        | command[2:0] process_id[18:3] priority_in[22:19]
//            |                   | memory_in[35:23], zero fill to 40 bits
//  result    | o_m_axis_*        | status[2:0] result_id[18:3] result_priority[22:19]
//            |                   | result_memory[35:23] result_state[37:36]
//            |                   | done_count[53:38], zero fill to 56 bits
//
// For each command the slot ring rotates once past the single compare point to search
// and once more to write back.
// One command is in work at a time; the next is taken once the result is registered.
// A stalled result holds in the output register and blocks the next result and command.
// Reset is synchronous, active low; the table is empty and ids restart at one.
module process_table_priority_scheduler
    import ptps_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int ID_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // command, process_id, priority_in, memory_in
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata    // status, result_id, result_priority,
                                          // result_memory, result_state, done_count
);

    localparam int TW = $clog2(NUM_SLOTS);
    localparam int W  = (ID_BITS > 16) ? ID_BITS : 16;

    t_fsm r_state, n_state;

    logic [TW-1:0]      r_cnt;
    logic [2:0]         r_cmd;
    logic [15:0]        r_pid;
    logic [3:0]         r_prio;
    logic [12:0]        r_mem;
    logic               r_bfound;
    logic [TW-1:0]      r_btag;
    logic [ID_BITS-1:0] r_bid;
    logic [3:0]         r_bprio;
    logic [12:0]        r_bmem;
    logic [TW:0]        r_depth;
    logic [TW-1:0]      r_spos;
    logic [ID_BITS:0]   r_next_id;
    logic [15:0]        r_total;
    logic               r_apply;
    logic [2:0]         r_res_st;
    logic [15:0]        r_res_id;
    logic [3:0]         r_res_prio;
    logic [12:0]        r_res_mem;
    logic [1:0]         r_res_pst;
    logic               r_ovalid;
    logic [55:0]        r_odata;

    logic               w_valid [NUM_SLOTS];
    logic               w_ready [NUM_SLOTS];
    logic [ID_BITS-1:0] w_ident [NUM_SLOTS];
    logic [3:0]         w_prio  [NUM_SLOTS];
    logic [12:0]        w_mem   [NUM_SLOTS];
    logic [TW-1:0]      w_tag   [NUM_SLOTS];
    logic [TW-1:0]      w_spos  [NUM_SLOTS];

    logic               f_valid, f_ready;
    logic [ID_BITS-1:0] f_ident;
    logic [3:0]         f_prio;
    logic [12:0]        f_mem;
    logic [TW-1:0]      f_spos;

    logic               t_valid, t_ready;
    logic [ID_BITS-1:0] t_ident;
    logic [3:0]         t_prio;
    logic [12:0]        t_mem;
    logic [TW-1:0]      t_tag, t_spos;

    logic               shift, take, last, in_xfer, out_load;
    logic [W-1:0]       pid_ext, tid_ext, bid_ext;
    logic               prio_ok, mem_ok;

    assign t_valid = w_valid[NUM_SLOTS-1];
    assign t_ready = w_ready[NUM_SLOTS-1];
    assign t_ident = w_ident[NUM_SLOTS-1];
    assign t_prio  = w_prio[NUM_SLOTS-1];
    assign t_mem   = w_mem[NUM_SLOTS-1];
    assign t_tag   = w_tag[NUM_SLOTS-1];
    assign t_spos  = w_spos[NUM_SLOTS-1];

    genvar gi;
    generate
        for (gi = 0; gi < NUM_SLOTS; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                ptps_cell #(.ID_BITS(ID_BITS), .TW(TW), .IDX(gi)) u_cell (
                    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_shift(shift),
                    .i_valid(f_valid), .i_ready(f_ready), .i_ident(f_ident),
                    .i_prio(f_prio), .i_mem(f_mem), .i_tag(t_tag), .i_spos(f_spos),
                    .o_valid(w_valid[gi]), .o_ready(w_ready[gi]), .o_ident(w_ident[gi]),
                    .o_prio(w_prio[gi]), .o_mem(w_mem[gi]), .o_tag(w_tag[gi]),
                    .o_spos(w_spos[gi])
                );
            end else begin : g_body
                ptps_cell #(.ID_BITS(ID_BITS), .TW(TW), .IDX(gi)) u_cell (
                    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_shift(shift),
                    .i_valid(w_valid[gi-1]), .i_ready(w_ready[gi-1]),
                    .i_ident(w_ident[gi-1]), .i_prio(w_prio[gi-1]), .i_mem(w_mem[gi-1]),
                    .i_tag(w_tag[gi-1]), .i_spos(w_spos[gi-1]),
                    .o_valid(w_valid[gi]), .o_ready(w_ready[gi]), .o_ident(w_ident[gi]),
                    .o_prio(w_prio[gi]), .o_mem(w_mem[gi]), .o_tag(w_tag[gi]),
                    .o_spos(w_spos[gi])
                );
            end
        end
    endgenerate

    assign pid_ext = W'(r_pid);
    assign tid_ext = W'(t_ident);
    assign bid_ext = W'(r_bid);
    assign prio_ok = (r_prio >= PRIO_MIN) && (r_prio <= PRIO_MAX);
    assign mem_ok  = (r_mem >= MEM_MIN) && (r_mem <= MEM_MAX);
    assign last    = (r_cnt == TW'(NUM_SLOTS - 1));
    assign in_xfer = i_s_axis_tvalid && o_s_axis_tready;

    // search match for the entry at the compare point
    always_comb begin
        take = 1'b0;
        unique case (r_cmd)
            CMD_INSERT: take = !t_valid;
            CMD_FIND, CMD_DELETE, CMD_SETPRIO:
                take = t_valid && !t_ready && (tid_ext == pid_ext);
            CMD_DISPATCH:
                take = t_valid && !t_ready && (!r_bfound || (t_prio < r_bprio) ||
                       ((t_prio == r_bprio) && (t_ident > r_bid)));
            CMD_EXECUTE:
                take = t_valid && t_ready && (r_depth != '0) &&
                       (t_spos == TW'(r_depth - 1'b1));
            default: take = 1'b0;
        endcase
    end

    // write back on the second rotation
    always_comb begin
        f_valid = t_valid;
        f_ready = t_ready;
        f_ident = t_ident;
        f_prio  = t_prio;
        f_mem   = t_mem;
        f_spos  = t_spos;
        if (r_state == S_APPLY && r_apply && t_tag == r_btag) begin
            unique case (r_cmd)
                CMD_INSERT: begin
                    f_valid = 1'b1;
                    f_ready = 1'b0;
                    f_ident = r_bid;
                    f_prio  = r_prio;
                    f_mem   = r_mem;
                end
                CMD_DELETE:   f_valid = 1'b0;
                CMD_SETPRIO:  f_prio = r_prio;
                CMD_DISPATCH: begin
                    f_ready = 1'b1;
                    f_spos  = r_spos;
                end
                CMD_EXECUTE: begin
                    f_valid = 1'b0;
                    f_ready = 1'b0;
                end
                default: f_valid = t_valid;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_xfer) n_state = S_SCAN;
            S_SCAN:   if (last) n_state = S_DECIDE;
            S_DECIDE: n_state = S_APPLY;
            S_APPLY:  if (last) n_state = S_RESP;
            S_RESP:   if (!r_ovalid || i_m_axis_tready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == S_IDLE);
        shift           = (r_state == S_SCAN) || (r_state == S_APPLY);
        out_load        = (r_state == S_RESP) && (!r_ovalid || i_m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_depth   <= '0;
            r_next_id <= (ID_BITS+1)'(1);
            r_total   <= '0;
            r_ovalid  <= 1'b0;
            r_bfound  <= 1'b0;
            r_apply   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (shift && !last) ? r_cnt + 1'b1 : '0;
            if (in_xfer) begin
                r_bfound <= 1'b0;
            end else if (r_state == S_SCAN && take) begin
                r_bfound <= 1'b1;
            end
            if (r_state == S_DECIDE) begin
                r_apply <= 1'b0;
                unique case (r_cmd)
                    CMD_INSERT: if (!r_next_id[ID_BITS]) begin
                        r_next_id <= r_next_id + 1'b1;
                        r_apply   <= prio_ok && mem_ok && r_bfound;
                    end
                    CMD_DELETE:  r_apply <= r_bfound;
                    CMD_SETPRIO: r_apply <= r_bfound && prio_ok;
                    CMD_DISPATCH: if (r_bfound && r_depth < (TW+1)'(NUM_SLOTS)) begin
                        r_apply <= 1'b1;
                        r_depth <= r_depth + 1'b1;
                    end
                    CMD_EXECUTE: if (r_bfound) begin
                        r_apply <= 1'b1;
                        r_depth <= r_depth - 1'b1;
                        r_total <= r_total + 1'b1;
                    end
                    default: r_apply <= 1'b0;
                endcase
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd  <= i_s_axis_tdata[2:0];
            r_pid  <= i_s_axis_tdata[18:3];
            r_prio <= i_s_axis_tdata[22:19];
            r_mem  <= i_s_axis_tdata[35:23];
        end
        if (r_state == S_SCAN && take) begin
            r_btag  <= t_tag;
            r_bid   <= t_ident;
            r_bprio <= t_prio;
            r_bmem  <= t_mem;
        end
        if (r_state == S_DECIDE) begin
            r_spos     <= TW'(r_depth);
            r_res_st   <= ST_OK;
            r_res_id   <= '0;
            r_res_prio <= '0;
            r_res_mem  <= '0;
            r_res_pst  <= PS_NEW;
            unique case (r_cmd)
                CMD_INSERT: begin
                    if (r_next_id[ID_BITS]) r_res_st <= ST_NO_IDS;
                    else if (!prio_ok)      r_res_st <= ST_BAD_PRIO;
                    else if (!mem_ok)       r_res_st <= ST_BAD_MEM;
                    else if (!r_bfound)     r_res_st <= ST_FULL;
                    else begin
                        r_bid      <= r_next_id[ID_BITS-1:0];
                        r_res_id   <= 16'(W'(r_next_id[ID_BITS-1:0]));
                        r_res_prio <= r_prio;
                        r_res_mem  <= r_mem;
                    end
                end
                CMD_FIND, CMD_DELETE: begin
                    if (!r_bfound) r_res_st <= ST_NOT_FOUND;
                    else begin
                        r_res_id   <= bid_ext[15:0];
                        r_res_prio <= r_bprio;
                        r_res_mem  <= r_bmem;
                    end
                end
                CMD_SETPRIO: begin
                    if (!r_bfound)    r_res_st <= ST_NOT_FOUND;
                    else if (!prio_ok) r_res_st <= ST_BAD_PRIO;
                    else begin
                        r_res_id   <= bid_ext[15:0];
                        r_res_prio <= r_prio;
                        r_res_mem  <= r_bmem;
                    end
                end
                CMD_DISPATCH, CMD_EXECUTE: begin
                    if (!r_bfound || (r_cmd == CMD_DISPATCH &&
                                      r_depth >= (TW+1)'(NUM_SLOTS))) begin
                        r_res_st <= ST_EMPTY;
                    end else begin
                        r_res_id   <= bid_ext[15:0];
                        r_res_prio <= r_bprio;
                        r_res_mem  <= r_bmem;
                        r_res_pst  <= (r_cmd == CMD_DISPATCH) ? PS_READY : PS_TERMINATED;
                    end
                end
                default: r_res_st <= ST_OK;
            endcase
        end
        if (out_load) begin
            r_odata <= {2'b00, r_total, r_res_pst, r_res_mem, r_res_prio, r_res_id, r_res_st};
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

endmodule

// ===== rtl/ptps_checker.sv =====
// Port-level checks for the process table priority scheduler, bound to the top level.
// Depends on ptps_pkg and process_table_priority_scheduler.
module ptps_port_checks
    import ptps_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [39:0] i_s_axis_tdata,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [55:0] o_m_axis_tdata
);

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("command taken while another is in work");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[2:0] <= ST_NO_IDS))
        else $error("status code out of range");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[2:0] != ST_OK) |->
        (o_m_axis_tdata[37:3] == '0))
        else $error("failed command reports entry fields");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind process_table_priority_scheduler ptps_port_checks u_ptps_port_checks (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_s_axis_tvalid(i_s_axis_tvalid),
    .o_s_axis_tready(o_s_axis_tready),
    .i_s_axis_tdata(i_s_axis_tdata),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata(o_m_axis_tdata)
);

// ===== dv/ptps_checker.sv =====
// Checker for the process table priority scheduler: watches both stream channels,
// keeps its own copy of the process table and compares every result in order.
// Depends on ptps_pkg.
module ptps_checker
    import ptps_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int ID_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_tvalid,
    input  logic        i_cmd_tready,
    input  logic [39:0] i_cmd_tdata,   // command, process_id, priority_in, memory_in
    input  logic        i_res_tvalid,
    input  logic        i_res_tready,
    input  logic [55:0] i_res_tdata,   // status, result_id, result_priority,
                                       // result_memory, result_state, done_count
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] done;
        logic [1:0]  pstate;
        logic [12:0] mem;
        logic [3:0]  prio;
        logic [15:0] id;
        logic [2:0]  status;
    } t_result;

    logic        tbl_valid [NUM_SLOTS];
    logic        tbl_ready [NUM_SLOTS];
    logic [16:0] tbl_id    [NUM_SLOTS];
    logic [3:0]  tbl_prio  [NUM_SLOTS];
    logic [12:0] tbl_mem   [NUM_SLOTS];
    int          run_stack [NUM_SLOTS];
    int          run_depth;
    logic [16:0] id_next;
    logic [15:0] done_total;
    t_result     expected_results[$];

    function automatic t_result report(logic [2:0] st, int s, logic [1:0] ps, bit has);
        t_result r;
        r = '0;
        r.status = st;
        if (has) begin
            r.id = tbl_id[s][15:0];
            r.prio = tbl_prio[s];
            r.mem = tbl_mem[s];
            r.pstate = ps;
        end
        r.done = done_total;
        return r;
    endfunction

    function automatic int find_waiting(logic [15:0] pid);
        for (int i = 0; i < NUM_SLOTS; i++)
            if (tbl_valid[i] && !tbl_ready[i] && tbl_id[i] == {1'b0, pid})
                return i;
        return -1;
    endfunction

    function automatic t_result schedule_command(logic [39:0] d);
        logic [2:0]  cmd;
        logic [15:0] pid;
        logic [3:0]  prio;
        logic [12:0] mem;
        int          s;
        logic [16:0] nid;
        cmd = d[2:0];
        pid = d[18:3];
        prio = d[22:19];
        mem = d[35:23];
        s = -1;
        case (cmd)
            CMD_INSERT: begin
                if (id_next > ((17'd1 << ID_BITS) - 1)) return report(ST_NO_IDS, 0, PS_NEW, 0);
                nid = id_next;
                id_next++;
                if (prio < PRIO_MIN || prio > PRIO_MAX) return report(ST_BAD_PRIO, 0, PS_NEW, 0);
                if (mem < MEM_MIN || mem > MEM_MAX) return report(ST_BAD_MEM, 0, PS_NEW, 0);
                for (int i = NUM_SLOTS - 1; i >= 0; i--)
                    if (!tbl_valid[i]) s = i;
                if (s < 0) return report(ST_FULL, 0, PS_NEW, 0);
                tbl_valid[s] = 1;
                tbl_ready[s] = 0;
                tbl_id[s] = nid;
                tbl_prio[s] = prio;
                tbl_mem[s] = mem;
                return report(ST_OK, s, PS_NEW, 1);
            end
            CMD_FIND: begin
                s = find_waiting(pid);
                if (s < 0) return report(ST_NOT_FOUND, 0, PS_NEW, 0);
                return report(ST_OK, s, PS_NEW, 1);
            end
            CMD_DELETE: begin
                s = find_waiting(pid);
                if (s < 0) return report(ST_NOT_FOUND, 0, PS_NEW, 0);
                tbl_valid[s] = 0;
                return report(ST_OK, s, PS_NEW, 1);
            end
            CMD_SETPRIO: begin
                s = find_waiting(pid);
                if (s < 0) return report(ST_NOT_FOUND, 0, PS_NEW, 0);
                if (prio < PRIO_MIN || prio > PRIO_MAX) return report(ST_BAD_PRIO, 0, PS_NEW, 0);
                tbl_prio[s] = prio;
                return report(ST_OK, s, PS_NEW, 1);
            end
            CMD_DISPATCH: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!tbl_valid[i] || tbl_ready[i]) continue;
                    if (s < 0 || tbl_prio[i] < tbl_prio[s] ||
                        (tbl_prio[i] == tbl_prio[s] && tbl_id[i] > tbl_id[s]))
                        s = i;
                end
                if (s < 0 || run_depth >= NUM_SLOTS) return report(ST_EMPTY, 0, PS_NEW, 0);
                tbl_ready[s] = 1;
                run_stack[run_depth] = s;
                run_depth++;
                return report(ST_OK, s, PS_READY, 1);
            end
            CMD_EXECUTE: begin
                if (run_depth == 0) return report(ST_EMPTY, 0, PS_NEW, 0);
                run_depth--;
                s = run_stack[run_depth];
                tbl_valid[s] = 0;
                tbl_ready[s] = 0;
                done_total++;
                return report(ST_OK, s, PS_TERMINATED, 1);
            end
            default: return report(ST_OK, 0, PS_NEW, 0);
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                tbl_valid[i] = 0;
                tbl_ready[i] = 0;
            end
            run_depth = 0;
            id_next = 17'd1;
            done_total = '0;
            o_errors <= 0;
            o_results <= 0;
            o_pending <= 0;
            expected_results.delete();
        end else begin
            if (i_res_tvalid && i_res_tready) begin
                got = i_res_tdata[53:0];
                o_results <= o_results + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want || i_res_tdata[55:54] !== 2'b0) begin
                        $display("%0t: mismatch expected st=%0d id=%0d pr=%0d mem=%0d ps=%0d dn=%0d",
                                 $time, want.status, want.id, want.prio, want.mem,
                                 want.pstate, want.done);
                        $display("%0t:          actual st=%0d id=%0d pr=%0d mem=%0d ps=%0d dn=%0d",
                                 $time, got.status, got.id, got.prio, got.mem,
                                 got.pstate, got.done);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_cmd_tvalid && i_cmd_tready)
                expected_results.push_back(schedule_command(i_cmd_tdata));
            o_pending <= expected_results.size();
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the process table priority scheduler: clock, reset, command
// stimulus with idling phases and a long result hold-off; verdict from ptps_checker.
// Depends on ptps_pkg, process_table_priority_scheduler and ptps_checker.
module tb_top
    import ptps_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // command, process_id, priority_in, memory_in
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // status, result_id, result_priority, result_memory,
                            // result_state, done_count
    int          errors;
    int          pending;
    int          results;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off;
    int          sent;
    logic [16:0] ids_used;

    process_table_priority_scheduler u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready), .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready), .o_m_axis_tdata(m_tdata)
    );

    ptps_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_tvalid(s_tvalid), .i_cmd_tready(s_tready), .i_cmd_tdata(s_tdata),
        .i_res_tvalid(m_tvalid), .i_res_tready(m_tready), .i_res_tdata(m_tdata),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("tb_top: FAIL");
        $finish;
    end

    always_ff @(posedge i_clk) begin
        if (hold_off) m_tready <= 0;
        else m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send(logic [2:0] cmd, logic [15:0] pid, logic [3:0] prio, logic [12:0] mem);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge i_clk);
        end
        s_tvalid <= 1;
        s_tdata <= {4'b0, mem, prio, pid, cmd};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        if (cmd == CMD_INSERT) ids_used++;
        sent++;
    endtask

    function automatic logic [15:0] pick_id();
        if ($urandom_range(9) == 0) return 16'($urandom);
        return 16'(ids_used + 1 - $urandom_range(20));
    endfunction

    task automatic random_cmd();
        int k;
        k = $urandom_range(99);
        if (k < 35)
            send(CMD_INSERT, 16'($urandom), ($urandom_range(9) == 0) ? 4'($urandom)
                 : 4'($urandom_range(10, 1)),
                 ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(4096, 1)));
        else if (k < 45) send(CMD_FIND, pick_id(), 4'($urandom), 13'($urandom));
        else if (k < 53) send(CMD_DELETE, pick_id(), 4'($urandom), 13'($urandom));
        else if (k < 63) send(CMD_SETPRIO, pick_id(), ($urandom_range(7) == 0) ? 4'($urandom)
                              : 4'($urandom_range(10, 1)), 13'($urandom));
        else if (k < 80) send(CMD_DISPATCH, 16'($urandom), 4'($urandom), 13'($urandom));
        else if (k < 97) send(CMD_EXECUTE, 16'($urandom), 4'($urandom), 13'($urandom));
        else send(3'($urandom_range(7, 6)), 16'($urandom), 4'($urandom), 13'($urandom));
    endtask

    initial begin
        int wait_cycles;
        i_rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sent = 0;
        ids_used = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty table, bad fields, extremes, full table, ties
        send(CMD_EXECUTE, 0, 0, 0);
        send(CMD_DISPATCH, 0, 0, 0);
        send(CMD_FIND, 16'hFFFF, 0, 0);
        send(CMD_INSERT, 0, 4'd0, 13'd1);
        send(CMD_INSERT, 0, 4'd11, 13'd1);
        send(CMD_INSERT, 0, 4'd15, 13'd1);
        send(CMD_INSERT, 0, 4'd1, 13'd0);
        send(CMD_INSERT, 0, 4'd1, 13'd4097);
        send(CMD_INSERT, 0, 4'd10, 13'h1FFF);
        for (int i = 0; i < 17; i++) send(CMD_INSERT, 16'hFFFF, 4'd5, 13'(4096 - i));
        send(CMD_SETPRIO, 16'd12, 4'd0, 0);
        send(CMD_SETPRIO, 16'd12, 4'd1, 0);
        send(CMD_SETPRIO, 16'd60000, 4'd1, 0);
        send(CMD_FIND, 16'd10, 0, 0);
        send(CMD_DELETE, 16'd11, 0, 0);
        send(CMD_DELETE, 16'd11, 0, 0);
        send(3'd6, 16'hFFFF, 4'hF, 13'h1FFF);
        send(3'd7, 0, 0, 0);
        for (int i = 0; i < 17; i++) send(CMD_DISPATCH, 0, 0, 0);
        send(CMD_FIND, 16'd12, 0, 0);
        for (int i = 0; i < 17; i++) send(CMD_EXECUTE, 0, 0, 0);

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = (phase == 1) ? 50 : (phase == 3) ? 27 : 0;
            recv_stall_pct = (phase == 2) ? 50 : (phase == 3) ? 27 : 0;
            if (phase == 2) begin
                hold_off <= 1;
                fork
                    begin
                        repeat (600) @(posedge i_clk);
                        hold_off <= 0;
                    end
                join_none
            end
            for (int j = 0; j < 450; j++) random_cmd();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int j = 0; j < 60; j++) random_cmd();
        s_tvalid <= 0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (60) @(posedge i_clk);
        $display("tb_top: %0d commands sent, %0d results checked, full table and empty stack",
                 sent, results);
        $display("tb_top: idle/stall phases and a 600-cycle result hold-off were run");
        if (errors == 0 && pending == 0) $display("tb_top: PASS");
        else $display("tb_top: FAIL");
        $finish;
    end
endmodule
